[rtl/dps_pkg.sv]
package dps_pkg;

    localparam int MAX_DEVICES_DEF = 12;

    localparam logic [23:0] POLL_RST      = 24'd30000;
    localparam logic [23:0] BACKOFF_RST   = 24'd45000;
    localparam logic [3:0]  THRESH_RST    = 4'd3;
    localparam logic [23:0] STALE_RST     = 24'd120000;
    localparam logic [3:0]  CAP_RST       = 4'd10;

    // configuration register indexes
    localparam logic [2:0] REG_POLL    = 3'd0;
    localparam logic [2:0] REG_BACKOFF = 3'd1;
    localparam logic [2:0] REG_THRESH  = 3'd2;
    localparam logic [2:0] REG_STALE   = 3'd3;
    localparam logic [2:0] REG_CAP     = 3'd4;

    // commands
    localparam logic [2:0] CMD_SIGHT    = 3'd0;
    localparam logic [2:0] CMD_SELECT   = 3'd1;
    localparam logic [2:0] CMD_CONNFAIL = 3'd2;
    localparam logic [2:0] CMD_RDVALID  = 3'd3;
    localparam logic [2:0] CMD_RDINVAL  = 3'd4;

    // result codes
    localparam logic [1:0] RC_OK    = 2'd0;
    localparam logic [1:0] RC_NOTF  = 2'd1;
    localparam logic [1:0] RC_FULL  = 2'd2;
    localparam logic [1:0] RC_NONE  = 2'd3;

    // one registry entry as stored in the RAM
    typedef struct packed {
        logic [47:0] address;
        logic [31:0] last_seen;
        logic [31:0] last_read;
        logic [3:0]  failures;
        logic        has_status;
        logic [15:0] last_status;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]  command;
        logic [47:0] device_address;
        logic [31:0] now_ms;
        logic [15:0] status_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_code;
        logic [3:0]  slot;
        logic [47:0] chosen_address;
        logic        publish;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WAIT,
        ST_DONE
    } t_state;

endpackage

[rtl/device_poll_scheduler_with_backoff.sv]
// Poll scheduler over a registry of up to MAX_DEVICES devices. Issue a command
// with i_start while o_busy is low; exactly one result strobes on o_done for a
// single cycle (commands 5 to 7 give none) and the receiver cannot stall it.
// A command scans the entry RAM one entry per cycle through its registered read
// port. A lookup stops at the entry that hits and a select at the first due
// entry; an empty registry skips the scan. o_busy stays high through the result
// cycle, so a new command is taken only after the result of the last one is out.
// The due check of a select uses one 24x5 multiply, registered before the compare.
// The RAM needs no clearing: entries at or above entry_count are never read.
module device_poll_scheduler_with_backoff
    import dps_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in         i_item,
    output logic        o_done,
    output t_out        o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int AW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_DEVICES);

    // configuration registers
    logic [23:0] r_poll, r_backoff, r_stale;
    logic [3:0]  r_thresh, r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll    <= POLL_RST;
            r_backoff <= BACKOFF_RST;
            r_thresh  <= THRESH_RST;
            r_stale   <= STALE_RST;
            r_cap     <= CAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_POLL:    r_poll    <= i_cfg_data;
                REG_BACKOFF: r_backoff <= i_cfg_data;
                REG_THRESH:  r_thresh  <= i_cfg_data[3:0];
                REG_STALE:   r_stale   <= i_cfg_data;
                REG_CAP:     r_cap     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // control state
    t_state        r_state, n_state;
    t_in           r_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_rr, n_rr;
    logic [CW-1:0] r_n, n_n;        // entries issued so far
    logic [AW-1:0] r_idx, n_idx;    // entry being issued
    logic [AW-1:0] r_cidx;          // entry whose data is on the RAM output
    logic          r_cvalid;
    logic          r_done, n_done;
    t_out          r_res, n_res;
    logic          r_found;
    logic          miss_end;
    // select pipeline: registered product
    logic [28:0]   r_bprod;
    logic          r_pvalid, r_pfresh, r_pnever, r_pbo;
    logic [31:0]   r_since;
    logic [AW-1:0] r_pidx;
    logic [47:0]   r_paddr;

    t_entry        rd_data;
    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [AW-1:0] raddr;

    // pending append of a new entry
    logic          r_add;
    logic [AW-1:0] r_add_idx;
    t_entry        r_add_e;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;

    dps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_DEVICES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    logic        accept;
    logic        is_sel;
    logic [31:0] now;
    logic        hit;
    logic [31:0] d_seen, d_read;
    logic [4:0]  fmul;
    logic        last_issue;
    logic [AW-1:0] idx_inc;
    logic [32:0] need;
    logic        due;

    assign accept = i_start && !o_busy;
    assign is_sel = (r_cmd.command == CMD_SELECT);
    assign now    = r_cmd.now_ms;
    assign hit    = r_cvalid && (rd_data.address == r_cmd.device_address);
    assign d_seen = now - rd_data.last_seen;
    assign d_read = now - rd_data.last_read;
    assign fmul   = 5'(rd_data.failures - r_thresh) + 5'd1;
    assign last_issue = (r_n == r_count);
    assign idx_inc = (32'(r_idx) + 32'd1 >= 32'(r_count)) ? '0 : AW'(r_idx + 1'b1);
    assign need   = 33'(r_poll) + 33'(r_pbo ? r_bprod : 29'd0);
    assign due    = r_pvalid && r_pfresh && (r_pnever || (33'(r_since) >= need));

    // lookup miss handled at end of scan: a sighting adds or reports full, others report not found
    assign miss_end = (r_state == ST_DONE) && !is_sel && !r_found;

    // next-state and datapath control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_rr    = r_rr;
        n_n     = r_n;
        n_idx   = r_idx;
        n_done  = 1'b0;
        n_res   = r_res;
        raddr   = r_idx;
        we      = 1'b0;
        waddr   = r_cidx;
        wdata   = rd_data;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_item.command <= CMD_RDINVAL) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_READ;
                    n_n     = '0;
                    // round-robin pointer stays below the entry count whenever the count is nonzero
                    n_idx   = (i_item.command == CMD_SELECT) ? r_rr : '0;
                    n_res   = '0;
                    if (i_item.command == CMD_SELECT) begin
                        n_res.result_code = RC_NONE;
                    end else if (i_item.command == CMD_RDVALID) begin
                        n_res.publish = 1'b1;
                    end
                end
            end
            ST_READ: begin
                // issue a read each cycle until all entries are out
                if (!last_issue) begin
                    n_n   = r_n + 1'b1;
                    n_idx = idx_inc;
                end
                if (!is_sel && hit) begin
                    n_state = ST_DONE;
                    n_res.result_code = RC_OK;
                    n_res.slot = 4'(r_cidx);
                    n_res.publish = 1'b0;
                    we = 1'b1;
                    unique case (r_cmd.command)
                        CMD_SIGHT: begin
                            wdata.last_seen = now;
                            if (rd_data.failures != '0 && 33'(d_read) > {8'd0, r_poll, 1'b0})
                                wdata.failures = rd_data.failures - 1'b1;
                        end
                        CMD_CONNFAIL: begin
                            wdata.failures = (5'(rd_data.failures) + 5'd1 > 5'(r_cap))
                                             ? r_cap : rd_data.failures + 1'b1;
                            wdata.last_read = now;
                        end
                        CMD_RDVALID: begin
                            if (!rd_data.has_status || rd_data.last_status != r_cmd.status_value) begin
                                n_res.publish = 1'b1;
                                wdata.has_status = 1'b1;
                                wdata.last_status = r_cmd.status_value;
                            end
                            wdata.last_read = now;
                            if (rd_data.failures != '0)
                                wdata.failures = rd_data.failures - 1'b1;
                        end
                        default: begin
                            wdata.failures = (5'(rd_data.failures) + 5'd1 > 5'(r_cap))
                                             ? r_cap : rd_data.failures + 1'b1;
                        end
                    endcase
                end else if (is_sel && due) begin
                    n_state = ST_DONE;
                    n_res.result_code = RC_OK;
                    n_res.slot = 4'(r_pidx);
                    n_res.chosen_address = r_paddr;
                    n_rr = (32'(r_pidx) + 32'd1 >= 32'(r_count)) ? '0 : AW'(r_pidx + 1'b1);
                end else if (last_issue && !r_cvalid && !(is_sel && r_pvalid)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                // no entry matched: append on a sighting, else not found
                if (miss_end) begin
                    n_res.slot = '0;
                    if (r_cmd.command == CMD_SIGHT) begin
                        n_res.result_code = (r_count == MAXC) ? RC_FULL : RC_OK;
                        n_res.slot        = (r_count == MAXC) ? 4'd0 : 4'(r_count);
                    end else begin
                        n_res.result_code = RC_NOTF;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rr     <= '0;
            r_done   <= 1'b0;
            r_cvalid <= 1'b0;
            r_pvalid <= 1'b0;
            r_found  <= 1'b0;
            r_add    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rr     <= n_rr;
            r_done   <= n_done;
            r_cvalid <= (r_state == ST_READ) && !last_issue && (n_state == ST_READ);
            r_pvalid <= is_sel && r_cvalid && (n_state == ST_READ);
            if (r_state == ST_IDLE) r_found <= 1'b0;
            else if (n_state == ST_DONE && r_state == ST_READ && !is_sel && hit)
                r_found <= 1'b1;
            r_count  <= n_count + CW'(miss_end && r_cmd.command == CMD_SIGHT
                                      && r_count != MAXC);
            r_add    <= miss_end && r_cmd.command == CMD_SIGHT && r_count != MAXC;
        end
    end

    // payload registers
    t_entry new_e;
    always_comb begin
        new_e = '0;
        new_e.address   = r_cmd.device_address;
        new_e.last_seen = r_cmd.now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) r_cmd <= i_item;
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_cidx <= r_idx;
        r_res  <= n_res;
        r_add_idx <= AW'(r_count);
        r_add_e   <= new_e;
        // due stage: multiply registered ahead of the compare
        r_bprod  <= 29'(r_backoff) * 29'(fmul);
        r_pbo    <= rd_data.failures >= r_thresh;
        r_pfresh <= d_seen <= 32'(r_stale);
        r_pnever <= rd_data.last_read == '0;
        r_since  <= d_read;
        r_pidx   <= r_cidx;
        r_paddr  <= rd_data.address;
    end

    assign ram_we    = we || r_add;
    assign ram_waddr = r_add ? r_add_idx : waddr;
    assign ram_wdata = r_add ? r_add_e : wdata;

    assign o_busy   = (r_state != ST_IDLE) || r_done || r_add;
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_DEVICES) else $error("entry count above limit");
    a_rr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (32'(r_rr) < 32'(r_count)))
        else $error("round-robin pointer beyond entry count");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than a cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.command <= CMD_RDINVAL) |=> o_busy)
        else $error("command not taken");
`endif

endmodule

[rtl/dps_ram.sv]
module dps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
